// ===== design/bcs_pkg.sv =====
// bcs_pkg: shared types and constants for the bucket counting sorter.
// No dependencies; imported by every module of the block.
package bcs_pkg;

  localparam int KEY_W   = 4;
  localparam int CNT_W   = 16;
  localparam int TDATA_W = 8;
  localparam int MDATA_W = 24;

  // item kind, carried on s_axis_tuser
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_POP    = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch item, start count read
    logic execute;  // update count, load result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_busy;  // result register full and not taken this cycle
  } dp_status_t;

endpackage

// ===== design/bucket_counting_sorter_core.sv =====
// Bucket counting sorter: one count per key, insert adds, pop takes the smallest held key.
// Every input beat gives exactly one result beat, in order. Each item is handled in order:
// first the bucket is picked (key, or lowest set bit of the nonempty map) and its count
// read from the single-port count memory into a register; then the updated count is
// written back and the result register loaded. A full result register holds the write-back
// until the result is taken, and a new beat is taken only once the item is done. Reset
// clears the nonempty map at once, so no clearing pass is needed. Depends on bcs_pkg, bcs_ctrl and bcs_datapath.
module bucket_counting_sorter_core
  import bcs_pkg::*;
#(
  parameter int NUM_BUCKETS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,   // [3:0] key_in, rest zero
  input  logic               s_axis_tuser,   // [0] mode
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [MDATA_W-1:0] m_axis_tdata,   // [3:0] key_out, [19:4] bucket_count, rest zero
  output logic [1:0]         m_axis_tuser    // [1:0] status
);

  cmd_t             cmd;
  dp_status_t       dp_status;
  logic [KEY_W-1:0] key_out;
  status_t          status;
  logic [CNT_W-1:0] bucket_count;

  bcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  bcs_datapath #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .mode         (s_axis_tuser),
    .key_in       (s_axis_tdata[KEY_W-1:0]),
    .out_ready    (m_axis_tready),
    .dp_status    (dp_status),
    .out_valid    (m_axis_tvalid),
    .key_out      (key_out),
    .status       (status),
    .bucket_count (bucket_count)
  );

  assign m_axis_tdata = {{(MDATA_W-KEY_W-CNT_W){1'b0}}, bucket_count, key_out};
  assign m_axis_tuser = status;

endmodule

// ===== design/bcs_ctrl.sv =====
// bcs_ctrl: two-state controller for the bucket counting sorter.
// Depends on bcs_pkg; drives bcs_datapath through cmd_t.
module bcs_ctrl
  import bcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t dp_status,
  output cmd_t       cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (!dp_status.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state)
      S_IDLE: begin
        // no beat taken while in reset
        in_ready    = !rst;
        cmd.capture = in_valid && !rst;
      end
      S_EXEC: begin
        // hold the update until the result register can take it
        cmd.execute = !dp_status.out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== design/bcs_datapath.sv =====
// bcs_datapath: count memory, nonempty map with lowest-key encoder, result register.
// Depends on bcs_pkg; sequenced by bcs_ctrl.
module bcs_datapath
  import bcs_pkg::*;
#(
  parameter int NUM_BUCKETS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  input  logic             mode,
  input  logic [KEY_W-1:0] key_in,
  input  logic             out_ready,
  output dp_status_t       dp_status,
  output logic             out_valid,
  output logic [KEY_W-1:0] key_out,
  output status_t          status,
  output logic [CNT_W-1:0] bucket_count
);

  localparam int IDX_W = $clog2(NUM_BUCKETS);

  logic [COUNT_BITS-1:0] mem [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] nonempty;

  logic                  item_mode;
  logic [KEY_W-1:0]      item_key;
  logic                  hit;
  logic [IDX_W-1:0]      addr;
  logic [COUNT_BITS-1:0] rd_count;

  // lowest nonempty bucket
  logic [NUM_BUCKETS-1:0] lowest;
  logic [IDX_W-1:0]       low_idx;
  logic                   any_held;

  always_comb begin
    lowest   = nonempty & (~nonempty + NUM_BUCKETS'(1));
    any_held = |nonempty;
    low_idx  = '0;
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      if (lowest[i]) low_idx = low_idx | IDX_W'(i);
    end
  end

  logic [KEY_W+IDX_W-1:0] key_wide;
  logic                   key_in_range;
  logic [IDX_W-1:0]       addr_sel;
  logic                   hit_sel;

  always_comb begin
    key_wide     = {{IDX_W{1'b0}}, key_in};
    key_in_range = 32'(key_in) < 32'(NUM_BUCKETS);
    if (mode == MODE_POP) begin
      addr_sel = low_idx;
      hit_sel  = any_held;
    end else begin
      addr_sel = key_wide[IDX_W-1:0];
      hit_sel  = key_in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_mode <= mode;
      item_key  <= key_in;
      hit       <= hit_sel;
      addr      <= addr_sel;
      rd_count  <= mem[addr_sel];
    end
  end

  // entries with a clear nonempty bit hold stale data and read as zero
  logic [COUNT_BITS-1:0]  cur;
  logic [COUNT_BITS-1:0]  new_count;
  logic                   wr_en;
  logic [KEY_W+IDX_W-1:0] addr_wide;
  logic [CNT_W+32-1:0]    cnt_wide;
  logic [KEY_W-1:0]       res_key;
  status_t                res_status;
  logic [COUNT_BITS-1:0]  res_count;

  always_comb begin
    cur        = nonempty[addr] ? rd_count : '0;
    new_count  = cur;
    wr_en      = 1'b0;
    addr_wide  = {{KEY_W{1'b0}}, addr};
    res_key    = addr_wide[KEY_W-1:0];
    res_status = ST_OK;
    res_count  = '0;
    if (item_mode == MODE_INSERT) begin
      // insert echoes the key as given, even when it is beyond the buckets
      res_key = item_key;
      if (!hit) begin
        res_status = ST_FULL;
      end else if (cur == {COUNT_BITS{1'b1}}) begin
        res_status = ST_FULL;
        res_count  = cur;
      end else begin
        new_count = cur + COUNT_BITS'(1);
        wr_en     = 1'b1;
        res_count = new_count;
      end
    end else begin
      if (!hit) begin
        res_key    = '0;
        res_status = ST_EMPTY;
      end else begin
        new_count = cur - COUNT_BITS'(1);
        wr_en     = 1'b1;
        res_count = new_count;
      end
    end
    cnt_wide = {{(CNT_W+32-COUNT_BITS){1'b0}}, res_count};
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && wr_en) begin
      mem[addr] <= new_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nonempty <= '0;
    end else if (cmd.execute && wr_en) begin
      nonempty[addr] <= (new_count != '0);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.execute) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      key_out      <= res_key;
      status       <= res_status;
      bucket_count <= cnt_wide[CNT_W-1:0];
    end
  end

  assign dp_status.out_busy = out_valid && !out_ready;

endmodule

// ===== tb/bcs_sort_checker.sv =====
// bcs_sort_checker: watches both stream channels of the bucket counting sorter,
// predicts each result beat from its own copy of the bucket counts and compares.
// Depends on bcs_pkg.
module bcs_sort_checker
  import bcs_pkg::*;
#(
  parameter int NUM_BUCKETS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,   // [3:0] key_in, rest zero
  input  logic               s_axis_tuser,   // [0] mode
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [MDATA_W-1:0] m_axis_tdata,   // [3:0] key_out, [19:4] bucket_count, rest zero
  input  logic [1:0]         m_axis_tuser,   // [1:0] status
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic [KEY_W-1:0] key;
    status_t          status;
    logic [CNT_W-1:0] count;
  } sort_result_t;

  localparam logic [COUNT_BITS-1:0] TALLY_MAX = '1;

  logic [COUNT_BITS-1:0] key_tally [NUM_BUCKETS];
  sort_result_t          due_results [$];
  int                    fail_count = 0;

  // Applies one item to the tally and returns the result beat it must produce.
  function automatic sort_result_t sort_step(logic mode, logic [KEY_W-1:0] key);
    sort_result_t r;
    logic         found;
    int           i;
    r.key    = key;
    r.status = ST_OK;
    r.count  = '0;
    found    = 1'b0;
    if (mode == MODE_INSERT) begin
      if (int'(key) >= NUM_BUCKETS) begin
        r.status = ST_FULL;
      end else if (key_tally[key] == TALLY_MAX) begin
        r.status = ST_FULL;
        r.count  = CNT_W'(key_tally[key]);
      end else begin
        key_tally[key] = key_tally[key] + 1'b1;
        r.count        = CNT_W'(key_tally[key]);
      end
    end else begin
      r.key    = '0;
      r.status = ST_EMPTY;
      for (i = 0; i < NUM_BUCKETS; i++) begin
        if (!found && key_tally[i] != '0) begin
          found        = 1'b1;
          key_tally[i] = key_tally[i] - 1'b1;
          r.key        = KEY_W'(i);
          r.status     = ST_OK;
          r.count      = CNT_W'(key_tally[i]);
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    sort_result_t     want;
    logic [KEY_W-1:0] got_key;
    logic [CNT_W-1:0] got_count;
    if (rst) begin
      due_results.delete();
      for (int i = 0; i < NUM_BUCKETS; i++) key_tally[i] = '0;
    end else begin
      // check the outgoing beat first: it can never belong to this edge's input beat
      if (m_axis_tvalid && m_axis_tready) begin
        got_key   = m_axis_tdata[KEY_W-1:0];
        got_count = m_axis_tdata[KEY_W +: CNT_W];
        if (due_results.size() == 0) begin
          $error("unexpected result beat: key_out %0d status %0d bucket_count %0d",
                 got_key, m_axis_tuser, got_count);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (got_key !== want.key) begin
            $error("key_out: expected %0d, actual %0d", want.key, got_key);
            fail_count++;
          end
          if (m_axis_tuser !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
            fail_count++;
          end
          if (got_count !== want.count) begin
            $error("bucket_count: expected %0d, actual %0d", want.count, got_count);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        due_results.push_back(sort_step(s_axis_tuser, s_axis_tdata[KEY_W-1:0]));
    end
    errors  <= fail_count;
    pending <= due_results.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// tb_top: stimulus and verdict for bucket_counting_sorter_core; directed cases
// around the empty store, then random phases with idling.
// Depends on bcs_pkg, bcs_sort_checker and the block's RTL.
module tb_top
  import bcs_pkg::*;
();

  localparam int CYCLE_LIMIT = 50_000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;   // [3:0] key_in, rest zero
  logic               s_axis_tuser = MODE_INSERT;  // [0] mode
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [MDATA_W-1:0] m_axis_tdata;        // [3:0] key_out, [19:4] bucket_count, rest zero
  logic [1:0]         m_axis_tuser;        // [1:0] status

  int errors;
  int pending;
  int cycles = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;

  always #5 clk = ~clk;

  bucket_counting_sorter_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  bcs_sort_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .errors        (errors),
    .pending       (pending)
  );

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Returns at the edge where the beat is taken; tvalid stays high for the next call.
  task automatic push_item(input logic mode, input logic [KEY_W-1:0] key);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TDATA_W'(key);
    s_axis_tuser  <= mode;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Switches at random between insert-heavy, pop-heavy and balanced stretches so the store fills and empties often.
  task automatic run_random(input int n);
    int               run_left;
    int               pop_pct;
    logic             mode;
    logic [KEY_W-1:0] key;
    run_left = 0;
    pop_pct  = 50;
    repeat (n) begin
      if (run_left == 0) begin
        run_left = $urandom_range(40, 5);
        case ($urandom_range(2))
          0:       pop_pct = 25;
          1:       pop_pct = 70;
          default: pop_pct = 50;
        endcase
      end
      run_left--;
      mode = ($urandom_range(99) < pop_pct) ? MODE_POP : MODE_INSERT;
      case ($urandom_range(5))
        0:       key = '0;
        1:       key = '1;
        default: key = KEY_W'($urandom);
      endcase
      push_item(mode, key);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty store, key field ignored on pop
    push_item(MODE_POP, 4'd0);
    push_item(MODE_POP, 4'd15);
    push_item(MODE_INSERT, 4'd0);
    push_item(MODE_INSERT, 4'd15);
    push_item(MODE_INSERT, 4'd15);
    push_item(MODE_INSERT, 4'd7);
    push_item(MODE_INSERT, 4'd0);
    push_item(MODE_POP, 4'd9);
    push_item(MODE_POP, 4'd0);
    push_item(MODE_POP, 4'd15);
    push_item(MODE_POP, 4'd0);
    push_item(MODE_POP, 4'd5);
    push_item(MODE_POP, 4'd0);
    push_item(MODE_INSERT, 4'd9);
    push_item(MODE_INSERT, 4'd10);
    push_item(MODE_POP, 4'd2);
    push_item(MODE_POP, 4'd2);

    send_gap_pct = 0;  recv_stall_pct = 0;  run_random(320);
    send_gap_pct = 66; recv_stall_pct = 0;  run_random(320);
    send_gap_pct = 0;  recv_stall_pct = 66; run_random(320);
    send_gap_pct = 7;  recv_stall_pct = 7;  run_random(320);
    s_axis_tvalid <= 1'b0;

    // pending is registered from the checker's queue size, so it trails the queue
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
